// File: rtl/core/atp_pkg.sv
package atp_pkg;

  localparam int CHAR_W     = 8;
  localparam int ADDR_BYTES = 6;
  localparam int ADDR_W     = 8 * ADDR_BYTES;
  localparam int SECTION_W  = 9;
  localparam int COUNT_W    = 3;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] SEP_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] SEP_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;

  localparam logic [3:0] HEX_A_VALUE = 4'ha;

  localparam logic [COUNT_W-1:0] LAST_DEC = 3'd3;
  localparam logic [COUNT_W-1:0] LAST_HEX = 3'd5;

  localparam logic [SECTION_W-1:0] SECTION_LIMIT = 9'd255;
  localparam logic [SECTION_W-1:0] SECTION_SAT   = 9'd511;

  typedef struct packed {
    logic [ADDR_W-1:0] address_bytes;
    logic              parse_error;
  } result_t;

endpackage

// File: rtl/core/address_text_parser_unit.sv
// Streaming parser for IPv4 dotted-decimal (hex_mode 0) or colon-separated hex MAC
// text (hex_mode 1), one character per request on the slave side. A character code
// of 0 ends a string and yields one result holding the six address bytes and an
// error flag; other characters yield nothing. Each character passes an input
// register and is then folded combinationally into the parser state, so the block
// takes one character per clock unless stalled, and a terminator's result is then
// loaded into the result register. The only stall is a terminator that finds
// the result register still full. Bytes that a string does not write keep their
// old values, and hex_mode should be changed only while no character is in flight.
module address_text_parser_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       hex_mode_we,
  input  logic                       hex_mode_wdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [atp_pkg::CHAR_W-1:0] s_tdata,   // char_code
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [atp_pkg::ADDR_W-1:0] m_tdata,   // address_bytes
  output logic                       m_tuser    // parse_error
);

  logic                       hex_mode;
  logic                       in_valid;
  logic [atp_pkg::CHAR_W-1:0] in_char;
  logic                       out_free;
  logic                       in_is_end;
  logic                       advance;
  atp_pkg::result_t           result;

  assign out_free  = !m_tvalid || m_tready;
  assign in_is_end = (in_char == atp_pkg::CHAR_NUL);
  assign advance   = in_valid && (!in_is_end || out_free);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_mode <= 1'b0;
    end else if (hex_mode_we) begin
      hex_mode <= hex_mode_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
  end

  atp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .hex_mode   (hex_mode),
    .step_valid (advance),
    .step_char  (in_char),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_is_end) begin
      m_tdata <= result.address_bytes;
      m_tuser <= result.parse_error;
    end
  end

endmodule

// File: rtl/core/atp_core.sv
module atp_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          hex_mode,
  input  logic                          step_valid,
  input  logic [atp_pkg::CHAR_W-1:0]    step_char,
  output atp_pkg::result_t              result
);

  logic [atp_pkg::ADDR_W-1:0]    address_store, address_store_next;
  logic [atp_pkg::SECTION_W-1:0] section_value, section_value_next;
  logic [atp_pkg::COUNT_W-1:0]   separator_count, separator_count_next;
  logic                          prev_was_separator, prev_was_separator_next;
  logic                          error_seen, error_seen_next;

  logic [atp_pkg::CHAR_W-1:0]    sep_char;
  logic [atp_pkg::COUNT_W-1:0]   last_index;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic [12:0]                   product;
  logic [12:0]                   accum;
  logic [atp_pkg::COUNT_W:0]     count_inc;
  logic                          write_en;
  logic [atp_pkg::COUNT_W-1:0]   write_index;

  assign sep_char   = hex_mode ? atp_pkg::SEP_COLON : atp_pkg::SEP_DOT;
  assign last_index = hex_mode ? atp_pkg::LAST_HEX : atp_pkg::LAST_DEC;
  assign count_inc  = {1'b0, separator_count} + 4'd1;

  always_comb begin
    is_digit = 1'b1;
    digit    = 4'd0;
    if (step_char inside {[8'h30:8'h39]}) begin
      digit = 4'(step_char - atp_pkg::CHAR_ZERO);
    end else if (hex_mode && (step_char inside {[8'h61:8'h66]})) begin
      digit = 4'(step_char - atp_pkg::CHAR_LOW_A) + atp_pkg::HEX_A_VALUE;
    end else if (hex_mode && (step_char inside {[8'h41:8'h46]})) begin
      digit = 4'(step_char - atp_pkg::CHAR_UP_A) + atp_pkg::HEX_A_VALUE;
    end else begin
      is_digit = 1'b0;
    end
  end

  always_comb begin
    if (hex_mode) begin
      product = {section_value, 4'b0};
    end else begin
      product = {1'b0, section_value, 3'b0} + {3'b0, section_value, 1'b0};
    end
    accum = product + {9'd0, digit};
  end

  always_comb begin
    address_store_next      = address_store;
    section_value_next      = section_value;
    separator_count_next    = separator_count;
    prev_was_separator_next = prev_was_separator;
    error_seen_next         = error_seen;
    write_en                = 1'b0;
    write_index             = last_index;

    if (step_char == atp_pkg::CHAR_NUL) begin
      if (!error_seen) begin
        if (section_value <= atp_pkg::SECTION_LIMIT) begin
          write_en = 1'b1;
        end else begin
          error_seen_next = 1'b1;
        end
      end
    end else if (!error_seen) begin
      if (step_char == sep_char) begin
        if ((count_inc > {1'b0, last_index}) || prev_was_separator ||
            (section_value > atp_pkg::SECTION_LIMIT)) begin
          error_seen_next = 1'b1;
        end else begin
          write_en                = 1'b1;
          write_index             = separator_count;
          separator_count_next    = count_inc[atp_pkg::COUNT_W-1:0];
          section_value_next      = '0;
          prev_was_separator_next = 1'b1;
        end
      end else if (!is_digit) begin
        error_seen_next = 1'b1;
      end else begin
        if (accum > 13'(atp_pkg::SECTION_SAT)) begin
          section_value_next = atp_pkg::SECTION_SAT;
        end else begin
          section_value_next = accum[atp_pkg::SECTION_W-1:0];
        end
        prev_was_separator_next = 1'b0;
      end
    end

    if (write_en) begin
      for (int b = 0; b < atp_pkg::ADDR_BYTES; b++) begin
        if (write_index == atp_pkg::COUNT_W'(b)) begin
          address_store_next[8*b +: 8] = section_value[7:0];
        end
      end
    end
  end

  assign result.address_bytes = address_store_next;
  assign result.parse_error   = error_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_store      <= '0;
      section_value      <= '0;
      separator_count    <= '0;
      prev_was_separator <= 1'b0;
      error_seen         <= 1'b0;
    end else if (step_valid) begin
      address_store <= address_store_next;
      if (step_char == atp_pkg::CHAR_NUL) begin
        section_value      <= '0;
        separator_count    <= '0;
        prev_was_separator <= 1'b0;
        error_seen         <= 1'b0;
      end else begin
        section_value      <= section_value_next;
        separator_count    <= separator_count_next;
        prev_was_separator <= prev_was_separator_next;
        error_seen         <= error_seen_next;
      end
    end
  end

endmodule

// File: rtl/core/atp_checker.sv
module atp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [atp_pkg::CHAR_W-1:0] s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [atp_pkg::ADDR_W-1:0] m_tdata,
  input logic                       m_tuser
);

  logic end_accepted;
  logic char_accepted;

  assign end_accepted  = s_tvalid && s_tready && (s_tdata == atp_pkg::CHAR_NUL);
  assign char_accepted = s_tvalid && s_tready && (s_tdata != atp_pkg::CHAR_NUL);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A new result follows its terminator request via the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(end_accepted, 2))
    else $error("result without a terminator two cycles earlier");

  // An ordinary character never produces a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    char_accepted ##1 !m_tvalid |=> !m_tvalid)
    else $error("result produced by a non-terminator character");

endmodule

bind address_text_parser_unit atp_checker u_atp_checker (.*);
